FILE: rtl/core/wma_pkg.sv
// shared constants and types of the windowed moving average core
package wma_pkg;

  // fixed field widths
  localparam int SampleW = 32;
  localparam int CountW  = 5;

  // sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StDiv,
    StWait
  } state_e;

endpackage

FILE: rtl/core/wma_if.sv
// stream interfaces for the sample and result channels

// sample channel
interface wma_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [wma_pkg::SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// result channel
interface wma_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [wma_pkg::SampleW-1:0] average;
  logic [wma_pkg::CountW-1:0]         valid_count;

  modport source (output valid, output average, output valid_count, input ready);
  modport sink (input valid, input average, input valid_count, output ready);
endinterface

FILE: rtl/core/wma_ring.sv
// sample ring memory, one write port and one registered read port
module wma_ring #(
  parameter int Depth = 16,
  parameter int Width = 32,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/wma_div.sv
// serial signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
module wma_div #(
  parameter int DividendW = 36,
  parameter int DivisorW  = 5,
  parameter int QuotW     = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]         divisor_i,
  output logic                        done_o,
  output logic signed [QuotW-1:0]     quotient_o
);

  localparam int StepW = $clog2(DividendW + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [StepW-1:0]     step_q;
  logic                 neg_q;
  logic [DividendW-1:0] mag_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW-1:0]  dvsr_q;

  logic [DivisorW:0]    rem_sh;
  logic                 fits;
  logic [DivisorW:0]    rem_nx;
  logic [DividendW-1:0] quot_full;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, mag_q[DividendW-1]};
    fits   = rem_sh >= {1'b0, dvsr_q};
    rem_nx = fits ? (rem_sh - {1'b0, dvsr_q}) : rem_sh;
  end

  // control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      neg_q  <= 1'b0;
      mag_q  <= '0;
      rem_q  <= '0;
      dvsr_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
      neg_q  <= dividend_i[DividendW-1];
      mag_q  <= dividend_i[DividendW-1] ? (-dividend_i) : dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      mag_q  <= {mag_q[DividendW-2:0], fits};
      rem_q  <= rem_nx[DivisorW-1:0];
      step_q <= step_q + StepW'(1);
      if (step_q == StepW'(DividendW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // restore sign of the quotient
  assign quot_full  = neg_q ? (-mag_q) : mag_q;
  assign quotient_o = quot_full[QuotW-1:0];
  assign done_o     = done_q;

endmodule

FILE: rtl/core/windowed_moving_average_core.sv
// top level of the windowed moving average core
//
// Usage: each transaction on sample_i carries one signed 32-bit reading. The
// reading goes into a ring of WINDOW entries, replacing the oldest one once
// the ring is full, and a running sum of the valid entries is updated. Each
// reading produces exactly one transaction on result_o: the sum divided by
// the number of valid entries (truncated toward zero) and that count.
// Sequence: the ring read of the oldest entry is registered, the serial
// divider then steps once per bit of the running sum (32 + clog2(WINDOW)
// bits, 36 at WINDOW = 16), and the quotient is loaded into the output
// register. One sample is in work at a time; the next is accepted only once
// the previous result has been placed in the output register.
// Reset clears the write slot, the fill count and the running sum; the ring
// contents are never read before written and need no clearing.
// Backpressure: the result sits in an output register; a new sample is
// accepted while it waits. A finished result that cannot be placed because
// the register is still full holds the sequencer until result_o is taken.
module windowed_moving_average_core #(
  parameter int WINDOW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  wma_sample_if.sink          sample_i,
  wma_result_if.source        result_o
);

  localparam int SampleW = wma_pkg::SampleW;
  localparam int CountW  = wma_pkg::CountW;
  localparam int IdxW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CntW    = $clog2(WINDOW + 1);
  localparam int SumW    = SampleW + $clog2(WINDOW);

  wma_pkg::state_e state_q, state_d;

  logic [IdxW-1:0]           slot_q, slot_d;
  logic [CntW-1:0]           filled_q, filled_d;
  logic signed [SumW-1:0]    total_q, total_d;
  logic signed [SampleW-1:0] sample_q;

  logic                      in_fire;
  logic                      ring_full;
  logic [SampleW-1:0]        old_data;
  logic signed [SumW-1:0]    old_ext;

  logic                      div_start;
  logic                      div_done;
  logic signed [SampleW-1:0] div_quot;

  logic                      out_free;
  logic                      out_load;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] avg_q;
  logic [CountW-1:0]         cnt_q;

  assign in_fire   = sample_i.valid && sample_i.ready;
  assign ring_full = filled_q == CntW'(WINDOW);
  assign out_free  = !out_valid_q || result_o.ready;

  // sample ring
  wma_ring #(
    .Depth (WINDOW),
    .Width (SampleW),
    .AddrW (IdxW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == wma_pkg::StRead),
    .wr_addr_i (slot_q),
    .wr_data_i (sample_q),
    .rd_en_i   (in_fire),
    .rd_addr_i (slot_q),
    .rd_data_o (old_data)
  );

  // running sum, fill count and write slot update
  always_comb begin
    old_ext  = ring_full ? SumW'($signed(old_data)) : '0;
    total_d  = total_q - old_ext + SumW'(sample_q);
    filled_d = ring_full ? filled_q : (filled_q + CntW'(1));
    slot_d   = (slot_q == IdxW'(WINDOW - 1)) ? '0 : (slot_q + IdxW'(1));
  end

  // mean divider
  wma_div #(
    .DividendW (SumW),
    .DivisorW  (CntW),
    .QuotW     (SampleW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_d),
    .divisor_i  (filled_d),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wma_pkg::StIdle: if (in_fire) state_d = wma_pkg::StRead;
      wma_pkg::StRead: state_d = wma_pkg::StDiv;
      wma_pkg::StDiv: begin
        if (div_done) state_d = out_free ? wma_pkg::StIdle : wma_pkg::StWait;
      end
      wma_pkg::StWait: if (out_free) state_d = wma_pkg::StIdle;
      default: state_d = wma_pkg::StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    sample_i.ready = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    unique case (state_q)
      wma_pkg::StIdle: sample_i.ready = 1'b1;
      wma_pkg::StRead: div_start = 1'b1;
      wma_pkg::StDiv:  out_load = div_done && out_free;
      wma_pkg::StWait: out_load = out_free;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wma_pkg::StIdle;
      slot_q      <= '0;
      filled_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == wma_pkg::StRead) begin
        slot_q   <= slot_d;
        filled_q <= filled_d;
        total_q  <= total_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_i.sample;
    end
    if (out_load) begin
      avg_q <= div_quot;
      cnt_q <= CountW'(filled_q);
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.average     = avg_q;
  assign result_o.valid_count = cnt_q;

endmodule
